// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants for the circular deque with rotation.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package cdq_pkg;

  // Fixed widths of the word fields on both channels.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Operation codes carried in a command word.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_ROT_FWD    = 3'd4,
    OP_ROT_BACK   = 3'd5,
    OP_READ_INDEX = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // Completion status reported in each response word.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // Control sequencer states.
  typedef enum logic {
    FSM_READY  = 1'b0,
    FSM_FINISH = 1'b1
  } fsm_t;

  // Command word.
  typedef struct packed {
    op_t               operation;
    logic [WORD_W-1:0] value;
    logic [3:0]        index;
  } cmd_t;

  // Response word.
  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  read_value;
    logic [WORD_W-1:0]  front_value;
    logic [WORD_W-1:0]  back_value;
    logic [COUNT_W-1:0] element_count;
    logic               is_empty;
  } rsp_t;

  // Which response fields take the RAM read data in the finish cycle.
  typedef struct packed {
    logic rd_from_mem;
    logic front_from_mem;
    logic back_from_mem;
  } mem_sel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/circular_deque_with_rotation_top.sv =====
// Top level of the circular deque with rotation: element RAM, pointers and sequencer.
// Depends on cdq_pkg for the word types, operation and status codes.
`default_nettype none

// Each command word passes through an accept cycle and a finish cycle. In the
// accept cycle the block computes the new head and count, performs at most one
// write and issues at most one read of the single-port-per-direction element
// RAM; in the finish cycle the registered read data completes the response
// word, which goes to an output register. The front and back elements are
// cached in registers, so no operation needs more than that one RAM read. No
// new command is taken before the last one's response is loaded; a waiting
// response holds the block in its finish cycle and stalls any command that
// arrives while it waits. The element RAM is not cleared after reset and
// needs no clearing pass: only entries inside the stored range are ever read.
module circular_deque_with_rotation_top
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  wire  rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > 4) ? CW : 4;
  localparam int unsigned EW   = ELEMENT_WIDTH;

  // Ring position base + off, correct for off not above DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Element RAM with registered read data.
  logic [EW-1:0] mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Architectural state and cached end elements.
  fsm_t          state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [EW-1:0] front, front_next;
  logic [EW-1:0] back, back_next;

  // Values carried from the accept cycle to the finish cycle.
  status_t       pend_status, status_next;
  logic [EW-1:0] pend_rd, rd_next;
  mem_sel_t      pend_sel, sel_next;

  logic          cmd_fire;
  logic          rsp_load;
  logic          is_zero, is_one, is_full;
  logic [AW-1:0] head_prev;
  logic [AW-1:0] head_succ;
  logic [AW-1:0] tail_succ;
  logic [AW-1:0] tail_prev;
  logic [EW-1:0] elem_in;

  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign rsp_load  = (state == FSM_FINISH) && (!rsp_valid || !rsp_stall);
  assign is_zero   = (count == '0);
  assign is_one    = (count == CW'(1));
  assign is_full   = (count == CW'(DEPTH));
  assign head_prev = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_succ = ring_add(head, CW'(1));
  assign tail_succ = ring_add(head, count);
  assign tail_prev = ring_add(head, count - CW'(2));
  assign elem_in   = EW'(cmd.value);

  // Accept cycle: pointer update, RAM write, RAM read request.
  always_comb begin
    head_next   = head;
    count_next  = count;
    front_next  = front;
    back_next   = back;
    mem_we      = 1'b0;
    mem_waddr   = head;
    mem_wdata   = elem_in;
    mem_re      = 1'b0;
    mem_raddr   = head_succ;
    status_next = STAT_OK;
    rd_next     = '0;
    sel_next    = '0;
    unique case (cmd.operation)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          head_next  = head_prev;
          count_next = count + CW'(1);
          mem_we     = 1'b1;
          mem_waddr  = head_prev;
          front_next = elem_in;
          if (is_zero) begin
            back_next = elem_in;
          end
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          count_next = count + CW'(1);
          mem_we     = 1'b1;
          mem_waddr  = tail_succ;
          back_next  = elem_in;
          if (is_zero) begin
            front_next = elem_in;
          end
        end
      end
      OP_POP_FRONT: begin
        if (is_zero) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_next    = front;
          head_next  = head_succ;
          count_next = count - CW'(1);
          if (!is_one) begin
            mem_re                  = 1'b1;
            mem_raddr               = head_succ;
            sel_next.front_from_mem = 1'b1;
          end
        end
      end
      OP_POP_BACK: begin
        if (is_zero) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_next    = back;
          count_next = count - CW'(1);
          if (!is_one) begin
            mem_re                 = 1'b1;
            mem_raddr              = tail_prev;
            sel_next.back_from_mem = 1'b1;
          end
        end
      end
      OP_ROT_FWD: begin
        if (is_zero) begin
          status_next = STAT_EMPTY;
        end else begin
          // The front element is copied behind the back one.
          mem_we    = 1'b1;
          mem_waddr = tail_succ;
          mem_wdata = front;
          head_next = head_succ;
          back_next = front;
          if (!is_one) begin
            mem_re                  = 1'b1;
            mem_raddr               = head_succ;
            sel_next.front_from_mem = 1'b1;
          end
        end
      end
      OP_ROT_BACK: begin
        if (is_zero) begin
          status_next = STAT_EMPTY;
        end else begin
          // The back element is copied ahead of the front one.
          mem_we     = 1'b1;
          mem_waddr  = head_prev;
          mem_wdata  = back;
          head_next  = head_prev;
          front_next = back;
          if (!is_one) begin
            mem_re                 = 1'b1;
            mem_raddr              = tail_prev;
            sel_next.back_from_mem = 1'b1;
          end
        end
      end
      OP_READ_INDEX: begin
        if (is_zero) begin
          status_next = STAT_EMPTY;
        end else if (CMPW'(cmd.index) >= CMPW'(count)) begin
          status_next = STAT_RANGE;
        end else begin
          mem_re               = 1'b1;
          mem_raddr            = ring_add(head, CW'(cmd.index));
          sel_next.rd_from_mem = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
    if (!cmd_fire) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_READY: begin
        if (cmd_fire) begin
          state_next = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (rsp_load) begin
          state_next = FSM_READY;
        end
      end
      default: begin
        state_next = FSM_READY;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd_stall = (state != FSM_READY);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_READY;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd_fire) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // Cached end elements and the values held for the finish cycle.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      front       <= front_next;
      back        <= back_next;
      pend_status <= status_next;
      pend_rd     <= rd_next;
      pend_sel    <= sel_next;
    end else if (rsp_load) begin
      if (pend_sel.front_from_mem) begin
        front <= mem_rdata;
      end
      if (pend_sel.back_from_mem) begin
        back <= mem_rdata;
      end
    end
  end

  // Response word assembled in the finish cycle.
  rsp_t          rsp_next;
  logic [EW-1:0] front_out, back_out, rd_out;

  always_comb begin
    front_out = pend_sel.front_from_mem ? mem_rdata : front;
    back_out  = pend_sel.back_from_mem ? mem_rdata : back;
    rd_out    = pend_sel.rd_from_mem ? mem_rdata : pend_rd;
    rsp_next.status        = pend_status;
    rsp_next.read_value    = WORD_W'(rd_out);
    rsp_next.front_value   = is_zero ? '0 : WORD_W'(front_out);
    rsp_next.back_value    = is_zero ? '0 : WORD_W'(back_out);
    rsp_next.element_count = COUNT_W'(count);
    rsp_next.is_empty      = is_zero;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdq_checker.sv =====
// Port-level checker for the circular deque with rotation, bound to the top level.
// Depends on cdq_pkg for the word types and status codes.
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
(
  input wire  clk,
  input wire  rst,
  input wire  cmd_valid,
  input wire  cmd_stall,
  input cmd_t cmd,
  input wire  rsp_valid,
  input wire  rsp_stall,
  input rsp_t rsp
);

  // A stalled response word stays valid and unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // Each accepted command word is followed by a busy cycle.
  a_cmd_spacing: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted in back-to-back cycles");

  // An empty deque reports no end elements and a zero count.
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      rsp.front_value == '0 && rsp.back_value == '0 && rsp.element_count == '0)
    else $error("empty deque reports elements");

  // An empty error leaves the deque empty and returns no data.
  a_empty_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_EMPTY |-> rsp.is_empty && rsp.read_value == '0)
    else $error("empty error on a non-empty deque");

  // A full error leaves a non-empty deque and returns no data.
  a_full_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_FULL |-> !rsp.is_empty && rsp.read_value == '0)
    else $error("full error with bad response fields");

endmodule

bind circular_deque_with_rotation_top cdq_checker u_cdq_checker (.*);

`default_nettype wire
